FILE: design/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

    // Width of one word of the used map and of a bit position within it.
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;
    localparam int LIM_W  = 6;

    // Fixed field widths of the request, result and register.
    localparam int IDX_W   = 10;
    localparam int COUNT_W = 11;
    localparam int KIND_W  = 2;

    // Request codes.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // Result of searching one map word for its lowest free bit.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
        logic             full;
    } find_t;

endpackage

FILE: design/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bba_ram
    import bba_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bba_find.sv
// Lowest-free-bit search over one word of the used map.
module bba_find
    import bba_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [LIM_W-1:0]  lim,
    output find_t             result
);

    logic [WORD_W-1:0] avail;

    // A bit is a candidate when it is clear and lies below the limit.
    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            avail[b] = !word[b] && (LIM_W'(b) < lim);
        end
    end

    // Priority encoder: the lowest candidate wins.
    always_comb
    begin
        result.found = |avail;
        result.full  = &word;
        result.pos   = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                result.pos = BIT_W'(b);
            end
        end
    end

endmodule

FILE: design/bitmap_block_allocator_core.sv
// Top level of the bitmap first-fit block allocator.
//
// Requests arrive on the input channel (in_valid, in_stall, kind, block_index);
// one result per request leaves on the output channel (out_valid, out_stall,
// status, alloc_index, query_free, free_count). A transfer happens on a rising
// edge with valid high and stall low. The block-count register is written
// through cfg_valid / cfg_ready / cfg_data, which is always ready.
// The used map lives in a RAM of 32-bit words with registered read data.
// A free or query passes through the states EVAL and RESP before the next
// request is accepted; a request rejected on transfer goes straight to RESP.
// An allocate reads the word at a pointer below which every word is full,
// and stays in EVAL, moving on one word for each full word skipped. The
// result is staged and then copied to the output register in RESP, and the
// next request may be accepted while it waits. After reset a clearing pass
// writes every map word with in_stall high. If out_stall holds a result, a
// following request is worked on and then waits until the output register is free.
module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [IDX_W-1:0]   block_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [IDX_W-1:0]   alloc_index,
    output logic               query_free,
    output logic [COUNT_W-1:0] free_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [AW-1:0]      word_reg, word_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_alloc_reg, res_alloc_next;
    logic               res_free_reg, res_free_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_status_reg, out_status_next;
    logic [IDX_W-1:0]   out_alloc_reg, out_alloc_next;
    logic               out_bfree_reg, out_bfree_next;
    logic [COUNT_W-1:0] out_fcount_reg, out_fcount_next;

    logic [CMP_W-1:0]  total_ext;
    logic [CMP_W-1:0]  n_ext;
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  free_cnt;
    logic [CMP_W-1:0]  in_idx_ext;
    logic              in_range;
    logic [AW-1:0]     in_word;
    logic              in_fire;
    logic [CMP_W-1:0]  base;
    logic [CMP_W-1:0]  diff;
    logic [LIM_W-1:0]  lim;
    logic              more;
    find_t             find_res;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // Effective block count and free count.
    assign total_ext = CMP_W'(total_reg);
    assign n_ext     = (total_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : total_ext;
    assign n_eff     = CNT_W'(n_ext);
    assign free_cnt  = (n_eff > cnt_reg) ? (n_eff - cnt_reg) : '0;

    // Request decoding.
    assign in_idx_ext = CMP_W'(block_index);
    assign in_range   = in_idx_ext < n_ext;
    assign in_word    = AW'(in_idx_ext >> BIT_W);
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;

    // Range of valid bits within the word under the allocation pointer.
    assign base = CMP_W'(ptr_reg) << BIT_W;
    assign diff = (n_ext > base) ? (n_ext - base) : '0;
    assign lim  = (diff >= CMP_W'(WORD_W)) ? LIM_W'(WORD_W) : LIM_W'(diff);
    assign more = diff > CMP_W'(WORD_W);

    bba_find u_find
    (
        .word   (ram_rdata),
        .lim    (lim),
        .result (find_res)
    );

    bba_ram
    #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    )
    u_map
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Map read address: issued on transfer, or the next word while scanning.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = (kind == KIND_ALLOC) ? ptr_reg : in_word;
            end
            ST_EVAL:
            begin
                ram_raddr = ptr_reg + AW'(1);
            end
            default:
            begin
                ram_raddr = ptr_reg;
            end
        endcase
    end

    // Map write: clearing pass, setting a granted bit or clearing a freed one.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = ram_rdata;
        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_EVAL:
            begin
                if (kind_reg == KIND_ALLOC && find_res.found)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg;
                    ram_wdata = ram_rdata | (WORD_W'(1) << find_res.pos);
                end
                else if (kind_reg == KIND_FREE && ram_rdata[bit_reg])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = word_reg;
                    ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_reg);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control sequencer and result staging.
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        ptr_next        = ptr_reg;
        kind_next       = kind_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_alloc_next  = res_alloc_reg;
        res_free_next   = res_free_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_alloc_next  = out_alloc_reg;
        out_bfree_next  = out_bfree_reg;
        out_fcount_next = out_fcount_reg;

        // The output register empties when its transfer completes.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next       = kind;
                    word_next       = in_word;
                    bit_next        = block_index[BIT_W-1:0];
                    res_status_next = 1'b1;
                    res_alloc_next  = '0;
                    res_free_next   = 1'b0;
                    if (kind == KIND_ALLOC && free_cnt != '0)
                    begin
                        state_next = ST_EVAL;
                    end
                    else if ((kind inside {KIND_FREE, KIND_QUERY}) && in_range)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_EVAL:
            begin
                state_next = ST_RESP;
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        if (find_res.found)
                        begin
                            res_status_next = 1'b0;
                            res_alloc_next  = IDX_W'(base | CMP_W'(find_res.pos));
                            cnt_next        = cnt_reg + CNT_W'(1);
                        end
                        else if (find_res.full && more)
                        begin
                            // Every bit of this word is used: move on to the next.
                            ptr_next   = ptr_reg + AW'(1);
                            state_next = ST_EVAL;
                        end
                    end
                    KIND_FREE:
                    begin
                        if (ram_rdata[bit_reg])
                        begin
                            res_status_next = 1'b0;
                            if (cnt_reg != '0)
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                            if (word_reg < ptr_reg)
                            begin
                                ptr_next = word_reg;
                            end
                        end
                    end
                    KIND_QUERY:
                    begin
                        res_status_next = 1'b0;
                        res_free_next   = !ram_rdata[bit_reg];
                    end
                    default:
                    begin
                        res_status_next = 1'b1;
                    end
                endcase
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_alloc_next  = res_alloc_reg;
                    out_bfree_next  = res_free_reg;
                    out_fcount_next = COUNT_W'(free_cnt);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration register.
    assign cfg_ready  = 1'b1;
    assign total_next = cfg_valid ? cfg_data : total_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_addr_reg  <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            total_reg     <= COUNT_W'(1024);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_alloc_reg  <= res_alloc_next;
        res_free_reg   <= res_free_next;
        out_status_reg <= out_status_next;
        out_alloc_reg  <= out_alloc_next;
        out_bfree_reg  <= out_bfree_next;
        out_fcount_reg <= out_fcount_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign alloc_index = out_alloc_reg;
    assign query_free  = out_bfree_reg;
    assign free_count  = out_fcount_reg;

endmodule
